// File: hdl/assert_macros.svh
// assertion helpers included by the quantizer rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define SGDQ_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("sgdq same-cycle check failed");

// next-cycle implication
`define SGDQ_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("sgdq next-cycle check failed");

`endif

// File: hdl/sgdq_pkg.sv
package sgdq_pkg;

   localparam int MAX_WIDTH_DEF = 1024;
   localparam int MAX_HEIGHT    = 4096;

   localparam int PIX_W        = 8;
   localparam int GRAD_W       = 11;
   localparam int MAG_W        = 11;
   localparam int DIR_W        = 2;
   localparam int ROW_W        = 12;
   localparam int WIDTH_REG_W  = 11;
   localparam int HEIGHT_REG_W = 13;
   localparam int CSR_DATA_W   = 13;
   localparam int CSR_INDEX_W  = 2;

   // sum of squares fits 21 bits; odd width keeps the root's start bit a power of four
   localparam int SQ_W   = 21;
   localparam int PROD_W = 25;

   localparam logic [WIDTH_REG_W-1:0]  FRAME_WIDTH_RESET  = 11'd640;
   localparam logic [HEIGHT_REG_W-1:0] FRAME_HEIGHT_RESET = 13'd480;
   localparam logic [MAG_W-1:0]        MAG_MIN_RESET      = 11'd1443;

   // tangent thresholds scaled by ten thousand
   localparam logic [PROD_W-1:0] TAN_SCALE = 25'd10000;
   localparam logic [PROD_W-1:0] TAN_LOW   = 25'd4142;
   localparam logic [PROD_W-1:0] TAN_HIGH  = 25'd24142;

   localparam logic [CSR_INDEX_W-1:0] CSR_FRAME_WIDTH  = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_FRAME_HEIGHT = 2'd1;

   typedef enum logic [DIR_W-1:0] {
      DIR_HORIZONTAL,
      DIR_DIAG_POS,
      DIR_VERTICAL,
      DIR_DIAG_NEG
   } dir_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ,
      ST_CALC,
      ST_SQUARE,
      ST_ROOT,
      ST_DONE
   } state_type;

endpackage

// File: hdl/sgdq_req_if.sv
interface sgdq_req_if;
   import sgdq_pkg::*;

   logic             valid;
   logic             ready;
   logic [PIX_W-1:0] pixel;

   modport source (output valid, output pixel, input ready);
   modport sink (input valid, input pixel, output ready);
endinterface

// File: hdl/sgdq_rsp_if.sv
interface sgdq_rsp_if;
   import sgdq_pkg::*;

   logic                     valid;
   logic                     ready;
   logic signed [GRAD_W-1:0] grad_x;
   logic signed [GRAD_W-1:0] grad_y;
   logic [MAG_W-1:0]         magnitude;
   logic [DIR_W-1:0]         direction;
   logic                     frame_last;
   logic [MAG_W-1:0]         frame_min_magnitude;
   logic [MAG_W-1:0]         frame_max_magnitude;

   modport source (
      output valid, output grad_x, output grad_y, output magnitude, output direction,
      output frame_last, output frame_min_magnitude, output frame_max_magnitude,
      input ready
   );
   modport sink (
      input valid, input grad_x, input grad_y, input magnitude, input direction,
      input frame_last, input frame_min_magnitude, input frame_max_magnitude,
      output ready
   );
endinterface

// File: hdl/sobel_gradient_direction_quantizer.sv
// a border pixel passes line buffer read and gradient, then returns to idle; an interior pixel
// passes line buffer read, gradient, squares, 11 root steps and the output register
// a new pixel is taken only in idle, once the last one is through; the done state stalls while
// the output holds a result not yet taken; the square root unit gives one bit per cycle, single line buffer port
// reset: synchronous; counters and frame min/max cleared, registers back to 640 x 480,
// line buffer contents left as they are (stale entries are read only in rows 0 and 1, which give no result)
`include "assert_macros.svh"

module sobel_gradient_direction_quantizer #(
   parameter int MAX_WIDTH = sgdq_pkg::MAX_WIDTH_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   sgdq_req_if.sink                              req_bus,
   sgdq_rsp_if.source                            rsp_bus,
   input  logic                                  csr_wr_en,
   input  logic [sgdq_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  logic [sgdq_pkg::CSR_DATA_W-1:0]       csr_wr_data
);
   import sgdq_pkg::*;

   localparam int COL_W = $clog2(MAX_WIDTH);

   state_type state_ff, state_in;

   logic [WIDTH_REG_W-1:0]  width_ff;
   logic [HEIGHT_REG_W-1:0] height_ff;
   logic [COL_W-1:0]        col_ff, col_in, w_last;
   logic [ROW_W-1:0]        row_ff, row_in, h_last;
   logic [MAG_W-1:0]        min_ff, min_in, max_ff, max_in;
   logic                    rsp_valid_ff, rsp_valid_in;

   logic                    req_ready;
   logic                    mem_we;
   logic                    load_rsp;

   // line buffer: upper byte two rows up, lower byte one row up
   logic [2*PIX_W-1:0]      line_mem [MAX_WIDTH];
   logic [2*PIX_W-1:0]      line_rd_ff;

   logic [PIX_W-1:0]        pix_ff;
   logic [PIX_W-1:0]        t0_ff, m0_ff, b0_ff, t1_ff, m1_ff, b1_ff;
   logic [PIX_W-1:0]        t2, m2, b2;
   logic [PIX_W+1:0]        right_sum, left_sum, bottom_sum, top_sum;
   logic signed [GRAD_W-1:0] gx_in, gy_in, gx_ff, gy_ff;
   logic                    last_ff;

   logic [GRAD_W-1:0]       abs_x, abs_y;
   logic [2*GRAD_W-1:0]     sq_x, sq_y;
   logic [PROD_W-1:0]       lhs_ff, lo_ff, hi_ff;

   logic [SQ_W-1:0]         n_ff, root_ff, bit_ff;
   logic [SQ_W:0]           trial;
   logic                    take;

   logic [MAG_W-1:0]        mag, new_min, new_max;
   dir_type                 dir;

   logic signed [GRAD_W-1:0] rsp_gx_ff, rsp_gy_ff;
   logic [MAG_W-1:0]        rsp_mag_ff, rsp_min_ff, rsp_max_ff;
   dir_type                 rsp_dir_ff;
   logic                    rsp_last_ff;

   // effective frame size, clamped
   always_comb begin
      if (width_ff < WIDTH_REG_W'(3)) begin
         w_last = COL_W'(2);
      end else if (int'(width_ff) > MAX_WIDTH) begin
         w_last = COL_W'(MAX_WIDTH - 1);
      end else begin
         w_last = COL_W'(width_ff - 1'b1);
      end
      if (height_ff < HEIGHT_REG_W'(3)) begin
         h_last = ROW_W'(2);
      end else if (int'(height_ff) > MAX_HEIGHT) begin
         h_last = ROW_W'(MAX_HEIGHT - 1);
      end else begin
         h_last = ROW_W'(height_ff - 1'b1);
      end
   end

   // window sums
   assign t2 = line_rd_ff[2*PIX_W-1:PIX_W];
   assign m2 = line_rd_ff[PIX_W-1:0];
   assign b2 = pix_ff;

   assign right_sum  = {2'b00, t2} + {1'b0, m2, 1'b0} + {2'b00, b2};
   assign left_sum   = {2'b00, t0_ff} + {1'b0, m0_ff, 1'b0} + {2'b00, b0_ff};
   assign bottom_sum = {2'b00, b0_ff} + {1'b0, b1_ff, 1'b0} + {2'b00, b2};
   assign top_sum    = {2'b00, t0_ff} + {1'b0, t1_ff, 1'b0} + {2'b00, t2};
   assign gx_in      = $signed({1'b0, right_sum}) - $signed({1'b0, left_sum});
   assign gy_in      = $signed({1'b0, bottom_sum}) - $signed({1'b0, top_sum});

   assign abs_x = gx_ff[GRAD_W-1] ? GRAD_W'(-gx_ff) : GRAD_W'(gx_ff);
   assign abs_y = gy_ff[GRAD_W-1] ? GRAD_W'(-gy_ff) : GRAD_W'(gy_ff);
   assign sq_x  = abs_x * abs_x;
   assign sq_y  = abs_y * abs_y;

   // one digit-by-digit root step
   assign trial = {1'b0, root_ff} + {1'b0, bit_ff};
   assign take  = {1'b0, n_ff} >= trial;

   assign mag     = root_ff[MAG_W-1:0];
   assign new_min = (mag < min_ff) ? mag : min_ff;
   assign new_max = (mag > max_ff) ? mag : max_ff;

   // sector from the scaled tangent compares
   always_comb begin
      if (gx_ff == '0) begin
         dir = (gy_ff == '0) ? DIR_HORIZONTAL : DIR_VERTICAL;
      end else if (lhs_ff >= hi_ff) begin
         dir = DIR_VERTICAL;
      end else if (gy_ff == '0 || (gx_ff[GRAD_W-1] == gy_ff[GRAD_W-1])) begin
         dir = (lhs_ff <= lo_ff) ? DIR_HORIZONTAL : DIR_DIAG_POS;
      end else begin
         dir = (lhs_ff < lo_ff) ? DIR_HORIZONTAL : DIR_DIAG_NEG;
      end
   end

   always_comb begin
      state_in     = state_ff;
      col_in       = col_ff;
      row_in       = row_ff;
      min_in       = min_ff;
      max_in       = max_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_bus.ready;
      req_ready    = 1'b0;
      mem_we       = 1'b0;
      load_rsp     = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_bus.valid) begin
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            state_in = ST_CALC;
         end
         ST_CALC: begin
            mem_we = 1'b1;
            if (col_ff == w_last) begin
               col_in = '0;
               row_in = (row_ff == h_last) ? '0 : row_ff + 1'b1;
            end else begin
               col_in = col_ff + 1'b1;
            end
            if (row_ff >= ROW_W'(2) && col_ff >= COL_W'(2)) begin
               state_in = ST_SQUARE;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_SQUARE: begin
            state_in = ST_ROOT;
         end
         ST_ROOT: begin
            if (bit_ff[0]) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_bus.ready) begin
               load_rsp     = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
               if (last_ff) begin
                  min_in = MAG_MIN_RESET;
                  max_in = '0;
               end else begin
                  min_in = new_min;
                  max_in = new_max;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      // any register write restarts the frame
      if (csr_wr_en) begin
         col_in = '0;
         row_in = '0;
         min_in = MAG_MIN_RESET;
         max_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         width_ff     <= FRAME_WIDTH_RESET;
         height_ff    <= FRAME_HEIGHT_RESET;
         col_ff       <= '0;
         row_ff       <= '0;
         min_ff       <= MAG_MIN_RESET;
         max_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         col_ff       <= col_in;
         row_ff       <= row_in;
         min_ff       <= min_in;
         max_ff       <= max_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en && csr_index == CSR_FRAME_WIDTH) begin
            width_ff <= csr_wr_data[WIDTH_REG_W-1:0];
         end
         if (csr_wr_en && csr_index == CSR_FRAME_HEIGHT) begin
            height_ff <= csr_wr_data[HEIGHT_REG_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         line_mem[col_ff] <= {m2, b2};
      end
      line_rd_ff <= line_mem[col_ff];
   end

   always_ff @(posedge clock) begin
      if (req_ready && req_bus.valid) begin
         pix_ff <= req_bus.pixel;
      end
      if (state_ff == ST_CALC) begin
         gx_ff   <= gx_in;
         gy_ff   <= gy_in;
         last_ff <= (row_ff == h_last) && (col_ff == w_last);
         t0_ff   <= t1_ff;
         m0_ff   <= m1_ff;
         b0_ff   <= b1_ff;
         t1_ff   <= t2;
         m1_ff   <= m2;
         b1_ff   <= b2;
      end
      if (state_ff == ST_SQUARE) begin
         n_ff    <= SQ_W'(sq_x + sq_y);
         root_ff <= '0;
         bit_ff  <= SQ_W'(1) << (SQ_W - 1);
         lhs_ff  <= TAN_SCALE * PROD_W'(abs_y);
         lo_ff   <= TAN_LOW * PROD_W'(abs_x);
         hi_ff   <= TAN_HIGH * PROD_W'(abs_x);
      end
      if (state_ff == ST_ROOT) begin
         if (take) begin
            n_ff    <= n_ff - SQ_W'(trial);
            root_ff <= (root_ff >> 1) + bit_ff;
         end else begin
            root_ff <= root_ff >> 1;
         end
         bit_ff <= bit_ff >> 2;
      end
      if (load_rsp) begin
         rsp_gx_ff   <= gx_ff;
         rsp_gy_ff   <= gy_ff;
         rsp_mag_ff  <= mag;
         rsp_dir_ff  <= dir;
         rsp_last_ff <= last_ff;
         rsp_min_ff  <= last_ff ? new_min : '0;
         rsp_max_ff  <= last_ff ? new_max : '0;
      end
   end

   assign req_bus.ready               = req_ready;
   assign rsp_bus.valid               = rsp_valid_ff;
   assign rsp_bus.grad_x              = rsp_gx_ff;
   assign rsp_bus.grad_y              = rsp_gy_ff;
   assign rsp_bus.magnitude           = rsp_mag_ff;
   assign rsp_bus.direction           = rsp_dir_ff;
   assign rsp_bus.frame_last          = rsp_last_ff;
   assign rsp_bus.frame_min_magnitude = rsp_min_ff;
   assign rsp_bus.frame_max_magnitude = rsp_max_ff;

   `SGDQ_ASSERT_NOW(a_col_in_row, clock, reset, 1'b1, col_ff <= w_last)
   `SGDQ_ASSERT_NOW(a_minmax_zero, clock, reset, rsp_valid_ff && !rsp_last_ff, rsp_min_ff == '0 && rsp_max_ff == '0)
   `SGDQ_ASSERT_NOW(a_minmax_order, clock, reset, rsp_valid_ff && rsp_last_ff, rsp_min_ff <= rsp_mag_ff && rsp_mag_ff <= rsp_max_ff)
   `SGDQ_ASSERT_NEXT(a_done_holds, clock, reset, state_ff == ST_DONE && rsp_valid_ff && !rsp_bus.ready, state_ff == ST_DONE)
   `SGDQ_ASSERT_NEXT(a_transfer_reads, clock, reset, req_bus.valid && req_bus.ready, state_ff == ST_READ)

endmodule
